>>> src/pcn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcn_pkg: shared definitions of the phase correlation normalizer
// Widths, CORDIC constants, the arctangent table and the control records
// that travel between the front end, the queue and the CORDIC units.
// ----------------------------------------------------------------------------
package pcn_pkg;

  // default parameter values
  localparam int BIN_COUNT_DEF    = 4096;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int CORDIC_STEPS_DEF = 16;

  // fixed field widths
  localparam int BIN_W   = 12;
  localparam int ANGLE_W = 32;
  localparam int Q14_W   = 16;
  localparam int ROT_W   = 33;
  localparam int ATAN_W  = 5;

  localparam int QUEUE_DEPTH = 2;

  // binary angles, a full turn is 2^32
  localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;

  // 1/K scaled by 2^30, start vector of the rotation
  localparam logic signed [ROT_W-1:0] INV_GAIN = 33'sh0_26DD_3B6A;
  localparam logic signed [Q14_W-1:0] Q14_ONE  = 16'sd16384;

  // per-item control record
  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             last;
    logic             null_pair;  // current or reference bin is all zero
  } item_ctrl_t;

  // vectoring result handed to the rotation unit
  typedef struct packed {
    item_ctrl_t         ctrl;
    logic [ANGLE_W-1:0] angle;
  } phase_diff_t;

  // iterative CORDIC unit sequencing
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RUN,
    CS_DONE
  } cordic_state_t;

  // atan(2^-i) as a binary angle
  function automatic logic [ANGLE_W-1:0] atan_lookup(input logic [ATAN_W-1:0] step);
    logic [ANGLE_W-1:0] a;
    case (step)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2F9;
      5'd15:   a = 32'h0000_517C;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A2F;
      5'd19:   a = 32'h0000_0517;
      5'd20:   a = 32'h0000_028B;
      5'd21:   a = 32'h0000_0145;
      5'd22:   a = 32'h0000_00A2;
      5'd23:   a = 32'h0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> src/pcn_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcn_if: valid/ready channels of the phase correlation normalizer
// pcn_in_if carries spectral bins, pcn_out_if carries unit phasors.
// ----------------------------------------------------------------------------
interface pcn_in_if import pcn_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [BIN_W-1:0]               bin_index;
  logic signed [SAMPLE_WIDTH-1:0] spec_re;
  logic signed [SAMPLE_WIDTH-1:0] spec_im;
  logic                           frame_end;

  modport source (output valid, bin_index, spec_re, spec_im, frame_end, input ready);
  modport sink   (input valid, bin_index, spec_re, spec_im, frame_end, output ready);
endinterface

interface pcn_out_if import pcn_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [BIN_W-1:0]        result_bin;
  logic signed [Q14_W-1:0] phase_cos;
  logic signed [Q14_W-1:0] phase_sin;
  logic                    result_last;

  modport source (output valid, result_bin, phase_cos, phase_sin, result_last, input ready);
  modport sink   (input valid, result_bin, phase_cos, phase_sin, result_last, output ready);
endinterface
`default_nettype wire

>>> src/pcn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcn_front: bin intake and reference spectrum store
// Stores the first frame, then reads the reference bin for every later bin,
// flags zero pairs and pushes the pair into the work queue.
// ----------------------------------------------------------------------------
module pcn_front import pcn_pkg::*; #(
  parameter int BIN_COUNT    = BIN_COUNT_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  pcn_in_if.sink                         in_ch,
  output logic                           push_valid,
  input  wire logic                      push_ready,
  output item_ctrl_t                     push_ctrl,
  output logic [4*SAMPLE_WIDTH-1:0]      push_data
);

  localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int PW = 2 * SAMPLE_WIDTH;

  // reference spectrum, {re, im} per bin
  logic [PW-1:0] ref_mem [BIN_COUNT];
  logic [PW-1:0] ref_rd_r;

  logic ref_valid_r;
  logic hold_valid_r;

  logic [BIN_W-1:0]        hold_bin_r;
  logic                    hold_last_r;
  logic                    hold_cur_zero_r;
  logic                    hold_in_range_r;
  logic [SAMPLE_WIDTH-1:0] hold_re_r;
  logic [SAMPLE_WIDTH-1:0] hold_im_r;

  logic          accept;
  logic          in_range;
  logic [AW-1:0] addr;
  logic          mem_we;
  logic          mem_re;
  logic          ref_zero;

  // intake handshake
  assign in_ch.ready = !hold_valid_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_range    = 32'(in_ch.bin_index) < 32'(BIN_COUNT);
  assign addr        = AW'(in_ch.bin_index);
  assign mem_we      = accept && !ref_valid_r && in_range;
  assign mem_re      = accept && ref_valid_r;

  // reference store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ref_mem[addr] <= {in_ch.spec_re, in_ch.spec_im};
    end
    if (mem_re) begin
      ref_rd_r <= ref_mem[addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      if (accept && !ref_valid_r && in_ch.frame_end) begin
        ref_valid_r <= 1'b1;
      end
      if (mem_re) begin
        hold_valid_r <= 1'b1;
      end else if (push_ready) begin
        hold_valid_r <= 1'b0;
      end
    end
  end

  // current bin waits beside the reference read
  always_ff @(posedge clk) begin
    if (mem_re) begin
      hold_bin_r      <= in_ch.bin_index;
      hold_last_r     <= in_ch.frame_end;
      hold_cur_zero_r <= (in_ch.spec_re == '0) && (in_ch.spec_im == '0);
      hold_in_range_r <= in_range;
      hold_re_r       <= in_ch.spec_re;
      hold_im_r       <= in_ch.spec_im;
    end
  end

  // out-of-range bins read as a zero reference
  assign ref_zero   = !hold_in_range_r || (ref_rd_r == '0);
  assign push_valid = hold_valid_r;

  always_comb begin
    push_ctrl.bin       = hold_bin_r;
    push_ctrl.last      = hold_last_r;
    push_ctrl.null_pair = hold_cur_zero_r || ref_zero;
  end

  assign push_data = {hold_re_r, hold_im_r, ref_rd_r};

  // nothing reaches the queue before the reference frame is complete
  a_no_hold_before_ref: assert property (@(posedge clk) disable iff (!rst_n)
    !ref_valid_r |-> !hold_valid_r)
    else $error("pcn_front: item held before reference complete");

  // a stalled pair keeps its reference data
  a_ref_rd_stable: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r && !push_ready |=> $stable(ref_rd_r) && hold_valid_r)
    else $error("pcn_front: reference data changed under stall");

endmodule
`default_nettype wire

>>> src/pcn_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcn_queue: short FIFO between front end and CORDIC back end
// Lets the intake and the CORDIC units stall independently.
// ----------------------------------------------------------------------------
module pcn_queue import pcn_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  logic push;
  logic pop;

  assign wr_ready = count_r != CW'(QUEUE_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("pcn_queue: fill count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> wr_ptr_r == rd_ptr_r)
    else $error("pcn_queue: empty queue with unequal pointers");

endmodule
`default_nettype wire

>>> src/pcn_vector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcn_vector: two-lane iterative CORDIC vectoring
// Finds the angles of the current and reference bins, one micro-rotation per
// cycle in each lane, and hands on their difference.
// ----------------------------------------------------------------------------
module pcn_vector import pcn_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  output logic                             q_ready,
  input  wire item_ctrl_t                  q_ctrl,
  input  wire logic [4*SAMPLE_WIDTH-1:0]   q_data,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output phase_diff_t                      res
);

  // sign, negation and CORDIC gain headroom
  localparam int XW = SAMPLE_WIDTH + 3;
  localparam int CW = $clog2(CORDIC_STEPS);

  cordic_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r;
  item_ctrl_t    ctrl_r;

  // lane 0: current bin, lane 1: reference bin
  logic signed [XW-1:0]      x_r   [2];
  logic signed [XW-1:0]      y_r   [2];
  logic [ANGLE_W-1:0]        z_r   [2];
  logic signed [XW-1:0]      x_nxt [2];
  logic signed [XW-1:0]      y_nxt [2];
  logic [ANGLE_W-1:0]        z_nxt [2];
  logic signed [XW-1:0]      ld_x  [2];
  logic signed [XW-1:0]      ld_y  [2];
  logic [ANGLE_W-1:0]        ld_z  [2];
  logic signed [XW-1:0]      xs    [2];
  logic signed [XW-1:0]      ys    [2];
  logic signed [SAMPLE_WIDTH-1:0] in_re [2];
  logic signed [SAMPLE_WIDTH-1:0] in_im [2];

  logic               last_step;
  logic               load;
  logic [ANGLE_W-1:0] atan_a;

  assign last_step = cnt_r == CW'(CORDIC_STEPS - 1);
  assign load      = (state_r == CS_IDLE) && q_valid;
  assign atan_a    = atan_lookup(ATAN_W'(cnt_r));

  assign in_re[0] = q_data[4*SAMPLE_WIDTH-1:3*SAMPLE_WIDTH];
  assign in_im[0] = q_data[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
  assign in_re[1] = q_data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign in_im[1] = q_data[SAMPLE_WIDTH-1:0];

  // lane datapath: pre-rotation into the right half plane, then one step
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ld_x[l] = XW'(in_re[l]);
      ld_y[l] = XW'(in_im[l]);
      ld_z[l] = '0;
      if (ld_x[l][XW-1]) begin
        ld_x[l] = -XW'(in_re[l]);
        ld_y[l] = -XW'(in_im[l]);
        ld_z[l] = HALF_TURN;
      end
      xs[l] = x_r[l] >>> cnt_r;
      ys[l] = y_r[l] >>> cnt_r;
      if (!y_r[l][XW-1]) begin
        x_nxt[l] = x_r[l] + ys[l];
        y_nxt[l] = y_r[l] - xs[l];
        z_nxt[l] = z_r[l] + atan_a;
      end else begin
        x_nxt[l] = x_r[l] - ys[l];
        y_nxt[l] = y_r[l] + xs[l];
        z_nxt[l] = z_r[l] - atan_a;
      end
    end
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_ready   = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      CS_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          state_nxt = CS_RUN;
        end
      end
      CS_RUN: begin
        if (last_step) begin
          state_nxt = CS_DONE;
        end
      end
      CS_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  // lane registers and step counter
  always_ff @(posedge clk) begin
    if (load) begin
      cnt_r  <= '0;
      ctrl_r <= q_ctrl;
      for (int l = 0; l < 2; l++) begin
        x_r[l] <= ld_x[l];
        y_r[l] <= ld_y[l];
        z_r[l] <= ld_z[l];
      end
    end else if (state_r == CS_RUN) begin
      cnt_r <= cnt_r + 1'b1;
      for (int l = 0; l < 2; l++) begin
        x_r[l] <= x_nxt[l];
        y_r[l] <= y_nxt[l];
        z_r[l] <= z_nxt[l];
      end
    end
  end

  // phase of current minus phase of reference, wraps at a full turn
  always_comb begin
    res.ctrl  = ctrl_r;
    res.angle = z_r[0] - z_r[1];
  end

endmodule
`default_nettype wire

>>> src/pcn_rotate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcn_rotate: iterative CORDIC rotation and Q1.14 output stage
// Turns the phase difference into a unit phasor and holds it in the
// output register until the sink takes it.
// ----------------------------------------------------------------------------
module pcn_rotate import pcn_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         diff_valid,
  output logic              diff_ready,
  input  wire phase_diff_t  diff,
  pcn_out_if.source         out_ch
);

  localparam int CW = $clog2(CORDIC_STEPS);

  cordic_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r;
  item_ctrl_t    ctrl_r;
  logic          flip_r;

  logic signed [ROT_W-1:0] x_r, y_r, z_r;
  logic signed [ROT_W-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [ROT_W-1:0] xs, ys, atan_s;

  logic [ANGLE_W-1:0] quad_sum;
  logic               ld_flip;
  logic [ANGLE_W-1:0] ld_angle;

  logic                    out_valid_r;
  logic [BIN_W-1:0]        out_bin_r;
  logic signed [Q14_W-1:0] out_cos_r;
  logic signed [Q14_W-1:0] out_sin_r;
  logic                    out_last_r;

  logic                    last_step;
  logic                    load;
  logic                    out_load;
  logic signed [Q14_W-1:0] cos_q;
  logic signed [Q14_W-1:0] sin_q;

  // round to Q1.14, optional negation, clamp to one
  function automatic logic signed [Q14_W-1:0] to_q14(input logic signed [ROT_W-1:0] v,
                                                     input logic neg);
    logic signed [ROT_W:0]   sum;
    logic signed [ROT_W-16:0] r;
    logic signed [ROT_W-15:0] rn;
    sum = (ROT_W+1)'(v) + (ROT_W+1)'(32768);
    r   = sum[ROT_W:16];
    rn  = neg ? -(ROT_W-14)'(r) : (ROT_W-14)'(r);
    if (rn > (ROT_W-14)'(Q14_ONE)) begin
      rn = (ROT_W-14)'(Q14_ONE);
    end else if (rn < -(ROT_W-14)'(Q14_ONE)) begin
      rn = -(ROT_W-14)'(Q14_ONE);
    end
    return Q14_W'(rn);
  endfunction

  assign last_step = cnt_r == CW'(CORDIC_STEPS - 1);
  assign load      = (state_r == CS_IDLE) && diff_valid;

  // fold angles outside a quarter turn around by half a turn
  assign quad_sum = diff.angle + QUARTER_TURN;
  assign ld_flip  = quad_sum[ANGLE_W-1];
  assign ld_angle = ld_flip ? diff.angle - HALF_TURN : diff.angle;

  // one micro-rotation
  always_comb begin
    xs     = x_r >>> cnt_r;
    ys     = y_r >>> cnt_r;
    atan_s = ROT_W'(atan_lookup(ATAN_W'(cnt_r)));
    if (!z_r[ROT_W-1]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - atan_s;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + atan_s;
    end
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    diff_ready = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      CS_IDLE: begin
        diff_ready = 1'b1;
        if (diff_valid) begin
          state_nxt = CS_RUN;
        end
      end
      CS_RUN: begin
        if (last_step) begin
          state_nxt = CS_DONE;
        end
      end
      CS_DONE: begin
        out_load = !out_valid_r || out_ch.ready;
        if (out_load) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  // rotation registers
  always_ff @(posedge clk) begin
    if (load) begin
      cnt_r  <= '0;
      ctrl_r <= diff.ctrl;
      flip_r <= ld_flip;
      x_r    <= INV_GAIN;
      y_r    <= '0;
      z_r    <= ROT_W'(signed'(ld_angle));
    end else if (state_r == CS_RUN) begin
      cnt_r <= cnt_r + 1'b1;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
    end
  end

  // zero pairs give the null phasor
  always_comb begin
    cos_q = to_q14(x_r, flip_r);
    sin_q = to_q14(y_r, flip_r);
    if (ctrl_r.null_pair) begin
      cos_q = '0;
      sin_q = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin_r  <= ctrl_r.bin;
      out_cos_r  <= cos_q;
      out_sin_r  <= sin_q;
      out_last_r <= ctrl_r.last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_bin  = out_bin_r;
  assign out_ch.phase_cos   = out_cos_r;
  assign out_ch.phase_sin   = out_sin_r;
  assign out_ch.result_last = out_last_r;

  a_null_pair_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && ctrl_r.null_pair |=> out_cos_r == '0 && out_sin_r == '0)
    else $error("pcn_rotate: zero pair gave a nonzero phasor");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cos_r <= Q14_ONE && out_cos_r >= -Q14_ONE &&
                    out_sin_r <= Q14_ONE && out_sin_r >= -Q14_ONE)
    else $error("pcn_rotate: phasor component beyond one");

endmodule
`default_nettype wire

>>> src/phase_correlation_normalizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phase_correlation_normalizer_unit: cross-power phase normalizer
// Bins of a 2D spectrum come in on in_ch (valid/ready). All bins up to and
// including the first frame_end form the reference spectrum and give no
// output; they are taken one per cycle. Every bin after that gives one
// transfer on out_ch: the unit phasor of its phase minus the reference
// bin's phase, cos and sin in signed Q1.14, with the bin index and the
// frame-end flag. A pair with an all-zero bin gives 0,0.
// The iterative vectoring unit takes no new bin until it has handed on the
// last one; meanwhile the rotation unit works on the previous bin.
// A two-entry queue sits between intake and the CORDIC units, and the
// output register lets the rotation finish a bin while the previous
// result waits. When out_ch stalls, results back up into the queue and
// then in_ch.ready drops. Reset clears the reference-valid flag so the
// next frame is stored again; the reference store itself is not cleared.
// ----------------------------------------------------------------------------
module phase_correlation_normalizer_unit import pcn_pkg::*; #(
  parameter int BIN_COUNT    = BIN_COUNT_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pcn_in_if.sink     in_ch,
  pcn_out_if.source  out_ch
);

  localparam int QW = $bits(item_ctrl_t) + 4 * SAMPLE_WIDTH;

  logic                        push_valid;
  logic                        push_ready;
  item_ctrl_t                  push_ctrl;
  logic [4*SAMPLE_WIDTH-1:0]   push_data;

  logic                        q_valid;
  logic                        q_ready;
  logic [QW-1:0]               q_word;
  item_ctrl_t                  q_ctrl;
  logic [4*SAMPLE_WIDTH-1:0]   q_data;

  logic                        diff_valid;
  logic                        diff_ready;
  phase_diff_t                 diff;

  // intake and reference store
  pcn_front #(
    .BIN_COUNT    (BIN_COUNT),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ctrl  (push_ctrl),
    .push_data  (push_data)
  );

  // decoupling queue
  pcn_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_ctrl, push_data}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_word)
  );

  assign q_ctrl = q_word[QW-1:4*SAMPLE_WIDTH];
  assign q_data = q_word[4*SAMPLE_WIDTH-1:0];

  // angle of both bins
  pcn_vector #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_vector (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_ctrl    (q_ctrl),
    .q_data    (q_data),
    .res_valid (diff_valid),
    .res_ready (diff_ready),
    .res       (diff)
  );

  // unit phasor of the difference
  pcn_rotate #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_rotate (
    .clk        (clk),
    .rst_n      (rst_n),
    .diff_valid (diff_valid),
    .diff_ready (diff_ready),
    .diff       (diff),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
